/* rtl/tfcp_pkg.sv */
// Shared types, codes and color helpers for the texel fetch/convert/place unit.
// No dependencies; imported by tfcp_locate, tfcp_convert and the top level under rtl/.
package tfcp_pkg;

    // Default sizes handed to the top level
    localparam int DEF_PALETTE_DEPTH    = 256;
    localparam int DEF_MAX_SOURCE_WIDTH = 512;

    // Item modes
    localparam logic [1:0] MODE_PAL_WRITE = 2'd0;
    localparam logic [1:0] MODE_LOCATE    = 2'd1;
    localparam logic [1:0] MODE_CONVERT   = 2'd2;
    localparam logic [1:0] MODE_NOP       = 2'd3;

    // Source formats
    localparam logic [2:0] FMT_RGBA16 = 3'd0;
    localparam logic [2:0] FMT_RGBA32 = 3'd1;
    localparam logic [2:0] FMT_IA8    = 3'd2;
    localparam logic [2:0] FMT_CI8    = 3'd3;
    localparam logic [2:0] FMT_I4     = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_SOURCE_FORMAT   = 3'd0;
    localparam logic [2:0] REG_TEXTURE_SHUFFLE = 3'd1;
    localparam logic [2:0] REG_ANCHOR_X        = 3'd2;
    localparam logic [2:0] REG_ANCHOR_Y        = 3'd3;
    localparam logic [2:0] REG_TARGET_WIDTH    = 3'd4;
    localparam logic [2:0] REG_TARGET_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_TARGET_PITCH    = 3'd6;
    localparam logic [2:0] REG_SOURCE_WIDTH    = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // Configuration register file contents
    typedef struct packed {
        logic [2:0]  source_format;
        logic        texture_shuffle;
        logic [9:0]  anchor_x;
        logic [9:0]  anchor_y;
        logic [9:0]  target_width;
        logic [9:0]  target_height;
        logic [10:0] target_pitch;
        logic [9:0]  source_width;
    } cfg_t;

    // Item fields kept past the input handshake
    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  strip_row;
        logic [8:0]  pixel_column;
        logic [8:0]  strip_top;
        logic [31:0] raw_texel;
    } item_t;

    // RGBA5551 to opaque-flagged BGR555; alpha clear gives transparent zero
    function automatic logic [15:0] conv_rgba16(input logic [15:0] c);
        logic [15:0] r;
        r = c[0] ? {1'b1, c[5:1], c[10:6], c[15:11]} : 16'h0000;
        return r;
    endfunction

    // Opaque grey from a 4-bit intensity
    function automatic logic [15:0] grey(input logic [3:0] i);
        logic [4:0] v;
        v = {i, i[3]};
        return {1'b1, v, v, v};
    endfunction

endpackage

/* rtl/tfcp_palette.sv */
// Palette store: one write port, one registered read port, slot wrapped to depth.
// Depends on nothing but its DEPTH parameter.
module tfcp_palette #(
    parameter int DEPTH = 256
) (
    input  logic        aclk,
    input  logic        wr_en,
    input  logic [7:0]  wr_slot,
    input  logic [15:0] wr_data,
    input  logic        rd_en,
    input  logic [7:0]  rd_slot,
    output logic [15:0] rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0]   mem [DEPTH];
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Reduce an 8-bit slot modulo DEPTH; quotient fits in four bits for DEPTH >= 16
    function automatic logic [AW-1:0] wrap_slot(input logic [7:0] v);
        logic [11:0] r;
        r = 12'(v);
        for (int k = 3; k >= 0; k--) begin
            if (r >= (12'(DEPTH) << k)) begin
                r = r - (12'(DEPTH) << k);
            end
        end
        return AW'(r);
    endfunction

    assign wr_addr = wrap_slot(wr_slot);
    assign rd_addr = wrap_slot(rd_slot);

    // Write on palette beats
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read on every accepted beat; hold otherwise
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/tfcp_locate.sv */
// Source element index with format swizzles, destination address and clip flag.
// Depends on tfcp_pkg for the config struct and format codes.
module tfcp_locate #(
    parameter int MAX_SOURCE_WIDTH = 512
) (
    input  tfcp_pkg::cfg_t cfg,
    input  logic [8:0]     strip_row,
    input  logic [8:0]     pixel_column,
    input  logic [8:0]     strip_top,
    output logic [17:0]    source_index,
    output logic [18:0]    target_address,
    output logic           target_inside
);
    import tfcp_pkg::*;

    localparam int SW_W   = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int PROD_W = 9 + SW_W;
    localparam logic [10:0] MAX_W11 = 11'(MAX_SOURCE_WIDTH);

    logic [10:0]       src_w11;
    logic [SW_W-1:0]   w;
    logic [SW_W-1:0]   half_w;
    logic [8:0]        col_x2;
    logic [8:0]        col_x3;
    logic [8:0]        col_sel;
    logic [SW_W-1:0]   mul_w;
    logic [PROD_W-1:0] prod;
    logic [PROD_W:0]   elem_sum;
    logic [11:0]       dx;
    logic [11:0]       dy;
    logic [21:0]       addr_sum;

    // Clamp the strip width
    assign src_w11 = 11'(cfg.source_width);
    assign w       = (src_w11 > MAX_W11) ? SW_W'(MAX_W11) : SW_W'(src_w11);
    assign half_w  = SW_W'(({1'b0, w} + 1'b1) >> 1);

    assign col_x2 = pixel_column ^ 9'd2;
    assign col_x3 = pixel_column ^ 9'd3;

    // Pick the column swizzle and row stride per format
    always_comb begin
        col_sel = pixel_column;
        mul_w   = w;
        unique case (cfg.source_format)
            FMT_RGBA16: begin
                if (cfg.texture_shuffle && strip_row[0] && (11'(col_x2) < 11'(w))) begin
                    col_sel = col_x2;
                end
            end
            FMT_CI8: begin
                if (11'(col_x3) < 11'(w)) begin
                    col_sel = col_x3;
                end
            end
            FMT_I4: begin
                col_sel = {1'b0, pixel_column[8:1]};
                mul_w   = half_w;
            end
            default: begin
                col_sel = pixel_column;
            end
        endcase
    end

    // Element index: one multiply, one add, halfword flip for rgba16
    assign prod     = PROD_W'(strip_row) * PROD_W'(mul_w);
    assign elem_sum = {1'b0, prod} + (PROD_W + 1)'(col_sel);
    assign source_index = (cfg.source_format == FMT_RGBA16) ?
                          (18'(elem_sum) ^ 18'd1) : 18'(elem_sum);

    // Destination position, signed 12 bits covers every sum
    assign dx = {{2{cfg.anchor_x[9]}}, cfg.anchor_x} + {3'b000, pixel_column};
    assign dy = {{2{cfg.anchor_y[9]}}, cfg.anchor_y} + {3'b000, strip_top}
              + {3'b000, strip_row};

    assign target_inside = !dx[11] && !dy[11]
                         && (dx[10:0] < {1'b0, cfg.target_width})
                         && (dy[10:0] < {1'b0, cfg.target_height});

    // Inside implies both coordinates below 1024
    assign addr_sum = 22'(dy[9:0]) * 22'(cfg.target_pitch) + 22'(dx[9:0]);
    assign target_address = target_inside ? 19'(addr_sum) : 19'd0;

endmodule

/* rtl/tfcp_convert.sv */
// Raw texel to opaque-flagged BGR555 color for every source format.
// Depends on tfcp_pkg for format codes and color helpers.
module tfcp_convert (
    input  logic [2:0]  source_format,
    input  logic [31:0] raw_texel,
    input  logic        column_odd,
    input  logic [15:0] palette_entry,
    output logic [15:0] color
);
    import tfcp_pkg::*;

    logic [7:0] b;
    logic [3:0] nib;

    assign b   = raw_texel[7:0];
    assign nib = column_odd ? b[3:0] : b[7:4];

    // Select the format's conversion
    always_comb begin
        unique case (source_format)
            FMT_RGBA16: color = conv_rgba16(raw_texel[15:0]);
            FMT_RGBA32: color = (b != 8'd0) ?
                                {1'b1, raw_texel[15:11], raw_texel[23:19], raw_texel[31:27]} :
                                16'h0000;
            FMT_IA8:    color = (b[3:0] != 4'd0) ? grey(b[7:4]) : 16'h0000;
            FMT_CI8:    color = conv_rgba16(palette_entry);
            FMT_I4:     color = (nib != 4'd0) ? grey(nib) : 16'h0000;
            default:    color = 16'h0000;
        endcase
    end

endmodule

/* rtl/texel_fetch_convert_place_unit.sv */
// Top level of the texel fetch/convert/place unit: config registers, input and
// result registers, palette store. Depends on tfcp_pkg, tfcp_palette,
// tfcp_locate and tfcp_convert.
//
//   channel | ports                        | beat carries
//   --------+------------------------------+---------------------------------------
//   input   | s_valid / s_ready            | mode, row, column, top, texel, palette
//   result  | m_valid / m_ready            | index, address, inside, color, opaque
//   config  | cfg_valid / cfg_ready        | register index, write data
//
// One item per clock sustained while m_ready stays high; a result passes through the
// input register, then the result register, the palette read sharing the first.
// The palette store has one write and one registered read port, both used at
// the input beat. Reset clears valid flags and loads register defaults; the
// palette is undefined until written. An upstream beat is taken while the
// result register empties or is being drained, so a stall on m_ready holds
// both stages. cfg_ready is always high.
module texel_fetch_convert_place_unit #(
    parameter int PALETTE_DEPTH    = tfcp_pkg::DEF_PALETTE_DEPTH,
    parameter int MAX_SOURCE_WIDTH = tfcp_pkg::DEF_MAX_SOURCE_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tfcp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tfcp_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_mode,
    input  logic [8:0]                         s_strip_row,
    input  logic [8:0]                         s_pixel_column,
    input  logic [8:0]                         s_strip_top,
    input  logic [31:0]                        s_raw_texel,
    input  logic [7:0]                         s_palette_slot,
    input  logic [15:0]                        s_palette_word,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [17:0]                        m_source_index,
    output logic [18:0]                        m_target_address,
    output logic                               m_target_inside,
    output logic [15:0]                        m_color_out,
    output logic                               m_is_opaque
);
    import tfcp_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    logic [17:0] sidx_reg;
    logic [18:0] addr_reg;
    logic        inside_reg;
    logic [15:0] color_reg;

    logic        s_beat;
    logic        out_load;
    logic [15:0] pal_entry;
    logic [17:0] loc_sidx;
    logic [18:0] loc_addr;
    logic        loc_inside;
    logic [15:0] conv_color;
    logic [17:0] sidx_next;
    logic [18:0] addr_next;
    logic        inside_next;
    logic [15:0] color_next;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_load  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || out_load;
    assign s_beat    = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_format   <= FMT_RGBA16;
            cfg_reg.texture_shuffle <= 1'b0;
            cfg_reg.anchor_x        <= 10'd0;
            cfg_reg.anchor_y        <= 10'd0;
            cfg_reg.target_width    <= 10'd320;
            cfg_reg.target_height   <= 10'd240;
            cfg_reg.target_pitch    <= 11'd320;
            cfg_reg.source_width    <= 10'd320;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SOURCE_FORMAT:   cfg_reg.source_format   <= cfg_data[2:0];
                REG_TEXTURE_SHUFFLE: cfg_reg.texture_shuffle <= cfg_data[0];
                REG_ANCHOR_X:        cfg_reg.anchor_x        <= cfg_data[9:0];
                REG_ANCHOR_Y:        cfg_reg.anchor_y        <= cfg_data[9:0];
                REG_TARGET_WIDTH:    cfg_reg.target_width    <= cfg_data[9:0];
                REG_TARGET_HEIGHT:   cfg_reg.target_height   <= cfg_data[9:0];
                REG_TARGET_PITCH:    cfg_reg.target_pitch    <= cfg_data[10:0];
                REG_SOURCE_WIDTH:    cfg_reg.source_width    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Palette: write and read both at the input beat
    tfcp_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (s_beat && (s_mode == MODE_PAL_WRITE)),
        .wr_slot (s_palette_slot),
        .wr_data (s_palette_word),
        .rd_en   (s_beat),
        .rd_slot (s_raw_texel[7:0] ^ 8'h01),
        .rd_data (pal_entry)
    );

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            item_reg.mode         <= s_mode;
            item_reg.strip_row    <= s_strip_row;
            item_reg.pixel_column <= s_pixel_column;
            item_reg.strip_top    <= s_strip_top;
            item_reg.raw_texel    <= s_raw_texel;
        end
    end

    tfcp_locate #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
    ) u_locate (
        .cfg            (cfg_reg),
        .strip_row      (item_reg.strip_row),
        .pixel_column   (item_reg.pixel_column),
        .strip_top      (item_reg.strip_top),
        .source_index   (loc_sidx),
        .target_address (loc_addr),
        .target_inside  (loc_inside)
    );

    tfcp_convert u_convert (
        .source_format (cfg_reg.source_format),
        .raw_texel     (item_reg.raw_texel),
        .column_odd    (item_reg.pixel_column[0]),
        .palette_entry (pal_entry),
        .color         (conv_color)
    );

    // Keep only the fields that the mode gives meaning
    always_comb begin
        sidx_next   = 18'd0;
        addr_next   = 19'd0;
        inside_next = 1'b0;
        color_next  = 16'h0000;
        unique case (item_reg.mode)
            MODE_LOCATE: begin
                sidx_next   = loc_sidx;
                addr_next   = loc_addr;
                inside_next = loc_inside;
            end
            MODE_CONVERT: begin
                color_next = conv_color;
            end
            MODE_PAL_WRITE, MODE_NOP: begin
                color_next = 16'h0000;
            end
            default: ;
        endcase
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            sidx_reg   <= sidx_next;
            addr_reg   <= addr_next;
            inside_reg <= inside_next;
            color_reg  <= color_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_source_index   = sidx_reg;
    assign m_target_address = addr_reg;
    assign m_target_inside  = inside_reg;
    assign m_color_out      = color_reg;
    assign m_is_opaque      = (color_reg != 16'h0000);

    // A free or draining result register must never block the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while result stage can advance");

    // A held input item moves to the result stage when it can
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && (!m_valid || m_ready)) |=> m_valid)
        else $error("input item did not advance");

    // A clipped destination carries a zero address
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_target_inside) |-> (m_target_address == 19'd0))
        else $error("address set outside target");

    // Every nonzero color carries the opaque bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_opaque) |-> m_color_out[15])
        else $error("opaque color without alpha bit");

    // A locate result has no color and a convert result has no placement
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_target_inside) |-> !m_is_opaque)
        else $error("result mixes locate and convert fields");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench for texel_fetch_convert_place_unit: directed and random items on the
// valid/ready input channel, each result beat checked against an in-bench predictor.
// Depends on tfcp_pkg and the RTL under rtl/.
module tb;
    import tfcp_pkg::*;

    localparam int PAL_DEPTH   = DEF_PALETTE_DEPTH;
    localparam int SRC_W_LIMIT = DEF_MAX_SOURCE_WIDTH;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  strip_row;
        logic [8:0]  pixel_column;
        logic [8:0]  strip_top;
        logic [31:0] raw_texel;
        logic [7:0]  palette_slot;
        logic [15:0] palette_word;
    } texel_req_t;

    typedef struct packed {
        logic [17:0] source_index;
        logic [18:0] target_address;
        logic        target_inside;
        logic [15:0] color_out;
        logic        is_opaque;
    } texel_rsp_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_mode          = '0;
    logic [8:0]             s_strip_row     = '0;
    logic [8:0]             s_pixel_column  = '0;
    logic [8:0]             s_strip_top     = '0;
    logic [31:0]            s_raw_texel     = '0;
    logic [7:0]             s_palette_slot  = '0;
    logic [15:0]            s_palette_word  = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [17:0]            m_source_index;
    logic [18:0]            m_target_address;
    logic                   m_target_inside;
    logic [15:0]            m_color_out;
    logic                   m_is_opaque;

    // Shadow of the register file and palette, in step with accepted beats
    logic [2:0]  cur_format   = FMT_RGBA16;
    logic        cur_shuffle  = 1'b0;
    int          cur_anchor_x = 0;
    int          cur_anchor_y = 0;
    int          cur_target_w = 320;
    int          cur_target_h = 240;
    int          cur_pitch    = 320;
    int          cur_source_w = 320;
    logic [15:0] palette_shadow [PAL_DEPTH];

    texel_rsp_t  pending_results [$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          error_count    = 0;
    int          cycle_count    = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    texel_fetch_convert_place_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_strip_row      (s_strip_row),
        .s_pixel_column   (s_pixel_column),
        .s_strip_top      (s_strip_top),
        .s_raw_texel      (s_raw_texel),
        .s_palette_slot   (s_palette_slot),
        .s_palette_word   (s_palette_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_source_index   (m_source_index),
        .m_target_address (m_target_address),
        .m_target_inside  (m_target_inside),
        .m_color_out      (m_color_out),
        .m_is_opaque      (m_is_opaque)
    );

    // RGBA5551 word to opaque-flagged BGR555; alpha clear means transparent
    function automatic logic [15:0] bgr_from_5551(input logic [15:0] c);
        logic [4:0] red, green, blue;
        red   = c[15:11];
        green = c[10:6];
        blue  = c[5:1];
        if (!c[0]) return 16'h0000;
        return {1'b1, blue, green, red};
    endfunction

    // Replicate a 4-bit intensity into a 5-bit grey on all three channels
    function automatic logic [15:0] grey_level(input logic [3:0] lum);
        int          lvl_i;
        logic [4:0]  lvl;
        lvl_i = int'(lum) * 2 + int'(lum) / 8;
        lvl   = lvl_i[4:0];
        return {1'b1, lvl, lvl, lvl};
    endfunction

    // Work out the result beat of one item; a palette write updates the shadow
    function automatic texel_rsp_t predict_texel_result(input texel_req_t req);
        texel_rsp_t  rsp;
        int          w, c, row, col, top, dx, dy, idx, addr;
        logic [7:0]  lo;
        logic [3:0]  nib;
        logic [15:0] color;
        rsp   = '0;
        color = 16'h0000;
        row   = int'(req.strip_row);
        col   = int'(req.pixel_column);
        top   = int'(req.strip_top);
        lo    = req.raw_texel[7:0];
        w     = (cur_source_w > SRC_W_LIMIT) ? SRC_W_LIMIT : cur_source_w;
        case (req.mode)
            MODE_PAL_WRITE: begin
                palette_shadow[req.palette_slot] = req.palette_word;
            end
            MODE_LOCATE: begin
                case (cur_format)
                    FMT_RGBA16: begin
                        c = col;
                        // odd rows swap column pairs unless the swap leaves the row
                        if (cur_shuffle && (row % 2 == 1) && ((col ^ 2) < w)) c = col ^ 2;
                        idx = (row * w + c) ^ 1;
                    end
                    FMT_CI8: begin
                        c = col ^ 3;
                        if (c >= w) c = col;
                        idx = row * w + c;
                    end
                    FMT_I4: idx = row * ((w + 1) / 2) + col / 2;
                    default: idx = row * w + col;
                endcase
                rsp.source_index = idx[17:0];
                dx = cur_anchor_x + col;
                dy = cur_anchor_y + top + row;
                if (dx >= 0 && dy >= 0 && dx < cur_target_w && dy < cur_target_h) begin
                    addr = dy * cur_pitch + dx;
                    rsp.target_inside  = 1'b1;
                    rsp.target_address = addr[18:0];
                end
            end
            MODE_CONVERT: begin
                case (cur_format)
                    FMT_RGBA16: color = bgr_from_5551(req.raw_texel[15:0]);
                    FMT_RGBA32: begin
                        if (lo != 8'h00)
                            color = {1'b1, req.raw_texel[15:11], req.raw_texel[23:19],
                                     req.raw_texel[31:27]};
                    end
                    FMT_IA8: begin
                        if (lo[3:0] != 4'h0) color = grey_level(lo[7:4]);
                    end
                    FMT_CI8: color = bgr_from_5551(palette_shadow[lo ^ 8'h01]);
                    FMT_I4: begin
                        nib = req.pixel_column[0] ? lo[3:0] : lo[7:4];
                        if (nib != 4'h0) color = grey_level(nib);
                    end
                    default: color = 16'h0000;
                endcase
                rsp.color_out = color;
                rsp.is_opaque = (color != 16'h0000);
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // Drop ready at the current stall rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Match every result beat against the oldest expectation
    always @(posedge aclk) begin
        texel_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual index %h color %h",
                         $time, m_source_index, m_color_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("source_index", 32'(want.source_index), 32'(m_source_index));
                check_field("target_address", 32'(want.target_address),
                            32'(m_target_address));
                check_field("target_inside", 32'(want.target_inside), 32'(m_target_inside));
                check_field("color_out", 32'(want.color_out), 32'(m_color_out));
                check_field("is_opaque", 32'(want.is_opaque), 32'(m_is_opaque));
            end
        end
    end

    // Present one item, hold it until the beat, then record its expectation
    task automatic send_item(input texel_req_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= req.mode;
        s_strip_row    <= req.strip_row;
        s_pixel_column <= req.pixel_column;
        s_strip_top    <= req.strip_top;
        s_raw_texel    <= req.raw_texel;
        s_palette_slot <= req.palette_slot;
        s_palette_word <= req.palette_word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_texel_result(req));
    endtask

    // Hold the sender until every expected result has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SOURCE_FORMAT:   cur_format   = val[2:0];
            REG_TEXTURE_SHUFFLE: cur_shuffle  = val[0];
            REG_ANCHOR_X:        cur_anchor_x = int'($signed(val[9:0]));
            REG_ANCHOR_Y:        cur_anchor_y = int'($signed(val[9:0]));
            REG_TARGET_WIDTH:    cur_target_w = int'(val[9:0]);
            REG_TARGET_HEIGHT:   cur_target_h = int'(val[9:0]);
            REG_TARGET_PITCH:    cur_pitch    = int'(val[10:0]);
            REG_SOURCE_WIDTH:    cur_source_w = int'(val[9:0]);
            default: ;
        endcase
    endtask

    // Reprogram every register once the block has gone idle
    task automatic set_config(input int fmt, input int shuffle, input int ox, input int oy,
                              input int tw, input int th, input int pitch, input int sw);
        drain_results();
        write_reg(REG_SOURCE_FORMAT, fmt[10:0]);
        write_reg(REG_TEXTURE_SHUFFLE, shuffle[10:0]);
        write_reg(REG_ANCHOR_X, ox[10:0]);
        write_reg(REG_ANCHOR_Y, oy[10:0]);
        write_reg(REG_TARGET_WIDTH, tw[10:0]);
        write_reg(REG_TARGET_HEIGHT, th[10:0]);
        write_reg(REG_TARGET_PITCH, pitch[10:0]);
        write_reg(REG_SOURCE_WIDTH, sw[10:0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic texel_req_t locate_req(input int row, input int col, input int top);
        texel_req_t r;
        r              = '0;
        r.mode         = MODE_LOCATE;
        r.strip_row    = row[8:0];
        r.pixel_column = col[8:0];
        r.strip_top    = top[8:0];
        return r;
    endfunction

    function automatic texel_req_t convert_req(input logic [31:0] raw, input int col);
        texel_req_t r;
        r              = '0;
        r.mode         = MODE_CONVERT;
        r.raw_texel    = raw;
        r.pixel_column = col[8:0];
        return r;
    endfunction

    function automatic texel_req_t palette_req(input int slot, input int word);
        texel_req_t r;
        r              = '0;
        r.mode         = MODE_PAL_WRITE;
        r.palette_slot = slot[7:0];
        r.palette_word = word[15:0];
        return r;
    endfunction

    // Random item, biased toward visible pixels, swizzle edges and transparent texels
    function automatic texel_req_t random_req();
        texel_req_t r;
        int         pick, dx, dy, row, col, top, w;
        pick           = $urandom_range(0, 99);
        r.strip_row    = 9'($urandom_range(0, 511));
        r.pixel_column = 9'($urandom_range(0, 511));
        r.strip_top    = 9'($urandom_range(0, 511));
        r.raw_texel    = $urandom;
        r.palette_slot = 8'($urandom_range(0, 255));
        r.palette_word = 16'($urandom_range(0, 65535));
        if (pick < 6)       r.mode = MODE_PAL_WRITE;
        else if (pick < 50) r.mode = MODE_LOCATE;
        else if (pick < 96) r.mode = MODE_CONVERT;
        else                r.mode = MODE_NOP;
        w = (cur_source_w > SRC_W_LIMIT) ? SRC_W_LIMIT : cur_source_w;
        case ($urandom_range(0, 3))
            0, 1: begin
                // aim at a pixel inside the target window
                dx  = int'($urandom_range(0, 1023)) % ((cur_target_w > 0) ? cur_target_w : 1);
                dy  = int'($urandom_range(0, 1023)) % ((cur_target_h > 0) ? cur_target_h : 1);
                top = $urandom_range(0, 31);
                col = dx - cur_anchor_x;
                row = dy - cur_anchor_y - top;
                if (col >= 0 && col < 512) r.pixel_column = col[8:0];
                if (row >= 0 && row < 512) begin
                    r.strip_row = row[8:0];
                    r.strip_top = top[8:0];
                end
            end
            2: begin
                // sit near the end of the source row
                col = w - 4 + int'($urandom_range(0, 7));
                if (col >= 0 && col < 512) r.pixel_column = col[8:0];
            end
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: r.raw_texel[7:0] = 8'h00;
            1: r.raw_texel[3:0] = 4'h0;
            2: r.raw_texel[7:4] = 4'h0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic random_config();
        int fmt, ox, oy, tw, th, pitch, sw;
        fmt = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        if ($urandom_range(0, 1)) begin
            ox = int'($urandom_range(0, 1023)) - 512;
            oy = int'($urandom_range(0, 1023)) - 512;
        end else begin
            ox = int'($urandom_range(0, 96)) - 32;
            oy = int'($urandom_range(0, 96)) - 32;
        end
        tw    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 512);
        th    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 512);
        pitch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
        case ($urandom_range(0, 9))
            0: sw = $urandom_range(513, 1023);
            1: sw = $urandom_range(0, 8);
            default: sw = $urandom_range(1, 512);
        endcase
        set_config(fmt, $urandom_range(0, 1), ox, oy, tw, th, pitch, sw);
    endtask

    // Fill every palette entry so that no indexed read hits an unwritten slot
    task automatic load_palette();
        for (int slot = 0; slot < PAL_DEPTH; slot++)
            send_item(palette_req(slot, $urandom_range(0, 65535)));
    endtask

    // Register defaults straight after reset
    task automatic test_reset_defaults();
        send_item(locate_req(0, 0, 0));
        send_item(locate_req(511, 511, 511));
        send_item(convert_req(32'hffff_ffff, 0));
        send_item(convert_req(32'h0000_fffe, 0));
    endtask

    // Odd-row column swap, including the case where it would leave the row
    task automatic test_rgba16_shuffle();
        set_config(int'(FMT_RGBA16), 1, 0, 0, 320, 240, 320, 6);
        send_item(locate_req(1, 1, 0));
        send_item(locate_req(1, 4, 0));
        send_item(locate_req(0, 1, 0));
    endtask

    // Alpha byte zero, top bits of each channel, intensity with zero alpha nibble
    task automatic test_rgba32_ia8();
        set_config(int'(FMT_RGBA32), 0, 0, 0, 320, 240, 320, 320);
        send_item(convert_req(32'hffff_ff00, 0));
        send_item(convert_req(32'hf8f8_f801, 0));
        set_config(int'(FMT_IA8), 0, 0, 0, 320, 240, 320, 320);
        send_item(convert_req(32'h0000_00f0, 0));
        send_item(convert_req(32'h0000_008f, 0));
    endtask

    // Palette lookup through index xor 1 and the reversed byte quad
    task automatic test_ci8_palette();
        set_config(int'(FMT_CI8), 0, 0, 0, 320, 240, 320, 6);
        send_item(palette_req('h11, 'hffff));
        send_item(palette_req('h10, 'h0000));
        send_item(convert_req(32'h0000_0010, 0));
        send_item(convert_req(32'h0000_0011, 0));
        send_item(locate_req(0, 4, 0));
        send_item(locate_req(2, 1, 0));
    endtask

    // Byte index of packed nibbles and nibble choice by column parity
    task automatic test_i4_nibbles();
        set_config(int'(FMT_I4), 0, 0, 0, 320, 240, 320, 7);
        send_item(locate_req(3, 5, 0));
        send_item(convert_req(32'h0000_000f, 0));
        send_item(convert_req(32'h0000_000f, 1));
    endtask

    // Unknown formats, no-op items, zero and oversized source width, range limits
    task automatic test_corner_settings();
        set_config(7, 1, 511, -512, 1023, 1023, 2047, 0);
        send_item(locate_req(511, 0, 1));
        send_item(locate_req(0, 511, 511));
        send_item(convert_req(32'hffff_ffff, 0));
        send_item('{mode: MODE_NOP, strip_row: 9'h1ff, pixel_column: 9'h1ff,
                    strip_top: 9'h1ff, raw_texel: 32'hffff_ffff, palette_slot: 8'hff,
                    palette_word: 16'hffff});
        set_config(5, 0, -512, 511, 1, 1, 1, 1023);
        send_item(locate_req(0, 511, 0));
    endtask

    // Random items across all idling mixes; each new setting first waits for the
    // pipeline to empty, which also covers the sender pausing for all results
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int setting = 0; setting < 5; setting++) begin
                random_config();
                repeat (50) send_item(random_req());
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        load_palette();
        test_reset_defaults();
        test_rgba16_shuffle();
        test_rgba32_ia8();
        test_ci8_palette();
        test_i4_nibbles();
        test_corner_settings();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* texel_fetch_convert_place_unit.f */
rtl/tfcp_pkg.sv
rtl/tfcp_palette.sv
rtl/tfcp_locate.sv
rtl/tfcp_convert.sv
rtl/texel_fetch_convert_place_unit.sv
sim/tb.sv
